// File: rtl/core/assert_macros.svh
// assertion helpers, empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// File: rtl/core/sitda_pkg.sv
package sitda_pkg;

  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

  typedef struct packed {
    logic load;
    logic dabble;
    logic drop;
    logic put_sign;
    logic put_digit;
  } cmd_t;

  typedef struct packed {
    logic last_bit;
    logic top_zero;
    logic one_left;
    logic negative;
  } sts_t;

endpackage

// File: rtl/core/sitda_datapath.sv
module sitda_datapath #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                           clk,
  input  logic signed [NUMBER_WIDTH-1:0] value,
  input  sitda_pkg::cmd_t                cmd,
  output sitda_pkg::sts_t                sts,
  output logic [6:0]                     character,
  output logic                           last
);
  import sitda_pkg::*;

  localparam int NumDigits = (NUMBER_WIDTH * 77) / 256 + 1;
  localparam int BcdW      = 4 * NumDigits;
  localparam int CntW      = $clog2(NUMBER_WIDTH);
  localparam int DigW      = $clog2(NumDigits + 1);

  logic [NUMBER_WIDTH-1:0] mag;
  logic [BcdW-1:0]         bcd;
  logic [BcdW-1:0]         bcd_adj;
  logic [CntW-1:0]         bitcnt;
  logic [DigW-1:0]         ndig;
  logic                    negative;
  logic [NUMBER_WIDTH-1:0] mag_in;

  assign mag_in = value[NUMBER_WIDTH-1] ? (~$unsigned(value)) + NUMBER_WIDTH'(1)
                                        : $unsigned(value);

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= mag_in;
      negative <= value[NUMBER_WIDTH-1];
      bcd      <= '0;
      bitcnt   <= '0;
      ndig     <= DigW'(NumDigits);
    end
    if (cmd.dabble) begin
      bcd    <= {bcd_adj[BcdW-2:0], mag[NUMBER_WIDTH-1]};
      mag    <= {mag[NUMBER_WIDTH-2:0], 1'b0};
      bitcnt <= bitcnt + CntW'(1);
    end
    if (cmd.drop || cmd.put_digit) begin
      bcd  <= {bcd[BcdW-5:0], 4'b0000};
      ndig <= ndig - DigW'(1);
    end
    if (cmd.put_sign) begin
      character <= CHAR_MINUS;
      last      <= 1'b0;
    end
    if (cmd.put_digit) begin
      character <= CHAR_ZERO + {3'b000, bcd[BcdW-1 -: 4]};
      last      <= (ndig == DigW'(1));
    end
  end

  assign sts.last_bit = (bitcnt == CntW'(NUMBER_WIDTH - 1));
  assign sts.top_zero = (bcd[BcdW-1 -: 4] == 4'd0);
  assign sts.one_left = (ndig == DigW'(1));
  assign sts.negative = negative;

endmodule

// File: rtl/core/sitda_ctrl.sv
module sitda_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            value_valid,
  output logic            value_ready,
  output logic            character_valid,
  input  logic            character_ready,
  input  sitda_pkg::sts_t sts,
  output sitda_pkg::cmd_t cmd
);
  import sitda_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_TRIM  = 5'b00100,
    S_SIGN  = 5'b01000,
    S_DIGIT = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   ovalid, ovalid_next;
  logic   slot;

  assign slot = !ovalid || character_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (value_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.dabble = 1'b1;
        if (sts.last_bit) state_next = S_TRIM;
      end
      S_TRIM: begin
        if (sts.top_zero && !sts.one_left) begin
          cmd.drop = 1'b1;
        end else if (sts.negative) begin
          state_next = S_SIGN;
        end else begin
          state_next = S_DIGIT;
        end
      end
      S_SIGN: begin
        if (slot) begin
          cmd.put_sign = 1'b1;
          state_next   = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (slot) begin
          cmd.put_digit = 1'b1;
          if (sts.one_left) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.put_sign || cmd.put_digit) begin
      ovalid_next = 1'b1;
    end else if (character_ready) begin
      ovalid_next = 1'b0;
    end else begin
      ovalid_next = ovalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  assign value_ready     = (state == S_IDLE);
  assign character_valid = ovalid;

  `ASSERT_NEVER(a_no_overwrite, clk, rst, (cmd.put_sign || cmd.put_digit) && ovalid && !character_ready, "pending character overwritten")
  `ASSERT_NEVER(a_sign_negative, clk, rst, cmd.put_sign && !sts.negative, "minus sign for a non-negative number")
  `ASSERT_NEVER(a_keep_one_digit, clk, rst, cmd.drop && sts.one_left, "last digit dropped")
  `ASSERT_PROP(a_last_to_idle, clk, rst, (cmd.put_digit && sts.one_left) |=> value_ready, "no return to idle after final digit")

endmodule

// File: rtl/core/signed_int_to_decimal_ascii.sv
// channel    signals                                  transfer when
// input      value_valid, value_ready, value          value_valid && value_ready
// output     character_valid, character_ready,        character_valid && character_ready
//            character, last
//
// one number passes through the one-bit-per-cycle shift-add-3 conversion, the one-digit-per-cycle
// leading zero trim and the digit output, one digit per cycle while the output is not stalled, with
// a minus sign first for a negative number
// a finished character waits in the output register while the next number is accepted
// output stalls hold the digit sequencer; synchronous reset clears control state only
module signed_int_to_decimal_ascii #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           value_valid,
  output logic                           value_ready,
  input  logic signed [NUMBER_WIDTH-1:0] value,
  output logic                           character_valid,
  input  logic                           character_ready,
  output logic [6:0]                     character,
  output logic                           last
);
  import sitda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sitda_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .value_valid     (value_valid),
    .value_ready     (value_ready),
    .character_valid (character_valid),
    .character_ready (character_ready),
    .sts             (sts),
    .cmd             (cmd)
  );

  sitda_datapath #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .value     (value),
    .cmd       (cmd),
    .sts       (sts),
    .character (character),
    .last      (last)
  );

endmodule
